### rtl/atfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfp_pkg
// Shared types, phase codes and keyword tables of the telemetry frame parser.
// ----------------------------------------------------------------------------
package atfp_pkg;

	localparam int PHASE_W = 5;
	localparam int KPOS_W  = 4;
	localparam int ACC_W   = 16;
	localparam int AGE_W   = 16;
	localparam int DATA_W  = 64;

	// parser phases: hunt, keyword tails, then one phase per frame body character
	localparam logic [PHASE_W-1:0] PHASE_HUNT     = 5'd0;
	localparam logic [PHASE_W-1:0] PHASE_ACK_TAIL = 5'd1;
	localparam logic [PHASE_W-1:0] PHASE_DAT_TAIL = 5'd2;
	localparam logic [PHASE_W-1:0] PHASE_FRAME    = 5'd3;
	localparam logic [PHASE_W-1:0] PHASE_LAST     = 5'd30;
	localparam logic [PHASE_W-1:0] BODY_LEN       = 5'd28;

	localparam logic [KPOS_W-1:0] KPOS_PREFIX_END = 4'd4;
	localparam logic [KPOS_W-1:0] KPOS_TAIL_START = 4'd5;
	localparam logic [KPOS_W-1:0] KPOS_TAIL_LAST  = 4'd6;
	localparam logic [KPOS_W-1:0] KPOS_INIT_LAST  = 4'd11;
	localparam logic [KPOS_W-1:0] KPOS_INIT_LEN   = 4'd12;
	localparam logic [KPOS_W-1:0] KPOS_KW_LEN     = 4'd7;
	localparam logic [KPOS_W-1:0] KPOS_DIGIT_SEEN = 4'd1;

	localparam logic [1:0] FIELD_THR = 2'd2;

	localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd2000;
	localparam logic [AGE_W-1:0] AGE_MAX       = 16'hFFFF;

	localparam logic [7:0] CH_DIGIT_MARK = "#";
	localparam logic [7:0] CH_SEP        = ":";
	localparam logic [7:0] CH_B          = "B";
	localparam logic [7:0] CH_A          = "A";
	localparam logic [7:0] CH_D          = "D";
	localparam logic [7:0] CH_ZERO       = "0";
	localparam logic [7:0] CH_NINE       = "9";

	localparam logic [19:0] LIMIT_WIDE   = 20'd65535;
	localparam logic [19:0] LIMIT_NARROW = 20'd255;

	typedef struct packed {
		logic [15:0] battery;
		logic [7:0]  throttle;
		logic [15:0] elevator;
		logic [15:0] aileron;
	} fields_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [KPOS_W-1:0]  kpos;
		logic [ACC_W-1:0]   acc;
		fields_t            pending;
		fields_t            held;
		logic               link;
		logic [AGE_W-1:0]   age;
	} state_t;

	// frame_valid sits in the lowest bit
	typedef struct packed {
		logic link_up;
		logic init_ack_seen;
		logic ack_seen;
		logic frame_error;
		logic frame_valid;
	} flags_t;

	// ":AIL#:ELV#:THR#:BAT#:BAS_EOF", # marks a digit field
	function automatic logic [7:0] body_char(input logic [PHASE_W-1:0] p);
		logic [7:0] c;
		unique case (p)
			5'd0, 5'd5, 5'd10, 5'd15, 5'd20: c = ":";
			5'd4, 5'd9, 5'd14, 5'd19:        c = CH_DIGIT_MARK;
			5'd1:  c = "A";
			5'd2:  c = "I";
			5'd3:  c = "L";
			5'd6:  c = "E";
			5'd7:  c = "L";
			5'd8:  c = "V";
			5'd11: c = "T";
			5'd12: c = "H";
			5'd13: c = "R";
			5'd16: c = "B";
			5'd17: c = "A";
			5'd18: c = "T";
			5'd21: c = "B";
			5'd22: c = "A";
			5'd23: c = "S";
			5'd24: c = "_";
			5'd25: c = "E";
			5'd26: c = "O";
			5'd27: c = "F";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] field_of(input logic [PHASE_W-1:0] p);
		logic [1:0] f;
		unique case (p)
			5'd9:    f = 2'd1;
			5'd14:   f = 2'd2;
			5'd19:   f = 2'd3;
			default: f = 2'd0;
		endcase
		return f;
	endfunction

	// "BAS_ACK" or "BAS_DAT"
	function automatic logic [7:0] kw_char(input logic dat, input logic [KPOS_W-1:0] k);
		logic [7:0] c;
		unique case (k)
			4'd0:    c = "B";
			4'd1:    c = "A";
			4'd2:    c = "S";
			4'd3:    c = "_";
			4'd4:    c = dat ? "D" : "A";
			4'd5:    c = dat ? "A" : "C";
			4'd6:    c = dat ? "T" : "K";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// link bring-up keyword
	function automatic logic [7:0] init_char(input logic [KPOS_W-1:0] k);
		logic [7:0] c;
		unique case (k)
			4'd0:    c = "B";
			4'd1:    c = "A";
			4'd2:    c = "S";
			4'd3:    c = "_";
			4'd4:    c = "I";
			4'd5:    c = "N";
			4'd6:    c = "I";
			4'd7:    c = "T";
			4'd8:    c = "_";
			4'd9:    c = "A";
			4'd10:   c = "C";
			4'd11:   c = "K";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### rtl/atfp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfp_step
// Next-state and result flags of the parser for one byte or one tick.
// ----------------------------------------------------------------------------
module atfp_step (
	input  atfp_pkg::state_t    cur,
	input  logic                cmd,
	input  logic [7:0]          rx_byte,
	input  logic [15:0]         timeout,
	output atfp_pkg::state_t    nxt,
	output atfp_pkg::flags_t    flags
);
	import atfp_pkg::*;

	logic                is_b;
	logic                is_digit;
	logic [PHASE_W-1:0]  p;
	logic [7:0]          t;
	logic [1:0]          field;
	logic [19:0]         acc_x10;
	logic [19:0]         limit;
	logic [AGE_W-1:0]    age_inc;
	logic                frame_bad;

	assign is_b     = (rx_byte == CH_B);
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign p        = cur.phase - PHASE_FRAME;
	assign t        = body_char(p);
	assign field    = field_of(p);
	assign acc_x10  = ({4'b0, cur.acc} << 3) + ({4'b0, cur.acc} << 1)
		+ {16'b0, rx_byte[3:0]};
	assign limit    = (field == FIELD_THR) ? LIMIT_NARROW : LIMIT_WIDE;
	assign age_inc  = (cur.age == AGE_MAX) ? cur.age : cur.age + 16'd1;

	always_comb begin
		nxt       = cur;
		flags     = '0;
		frame_bad = 1'b0;
		if (cmd) begin
			if (cur.link) begin
				nxt.age = age_inc;
				if (age_inc >= timeout) begin
					nxt.link  = 1'b0;
					nxt.age   = '0;
					nxt.phase = PHASE_HUNT;
					nxt.kpos  = '0;
					nxt.acc   = '0;
				end
			end
		end else if (!cur.link) begin
			if (cur.kpos < KPOS_INIT_LEN && rx_byte == init_char(cur.kpos)) begin
				if (cur.kpos == KPOS_INIT_LAST) begin
					flags.init_ack_seen = 1'b1;
					nxt.link  = 1'b1;
					nxt.age   = '0;
					nxt.phase = PHASE_HUNT;
					nxt.kpos  = '0;
					nxt.acc   = '0;
				end else begin
					nxt.kpos = cur.kpos + 4'd1;
				end
			end else begin
				nxt.phase = PHASE_HUNT;
				nxt.kpos  = {3'b0, is_b};
			end
		end else if (cur.phase >= PHASE_FRAME) begin
			if (p >= BODY_LEN) begin
				frame_bad = 1'b1;
			end else if (t == CH_DIGIT_MARK) begin
				if (is_digit) begin
					if (acc_x10 > limit) begin
						frame_bad = 1'b1;
					end else begin
						nxt.acc  = acc_x10[ACC_W-1:0];
						nxt.kpos = KPOS_DIGIT_SEEN;
					end
				end else if (cur.kpos == KPOS_DIGIT_SEEN && rx_byte == CH_SEP) begin
					unique case (field)
						2'd0: nxt.pending.aileron  = cur.acc;
						2'd1: nxt.pending.elevator = cur.acc;
						2'd2: nxt.pending.throttle = cur.acc[7:0];
						2'd3: nxt.pending.battery  = cur.acc;
					endcase
					nxt.acc   = '0;
					nxt.kpos  = '0;
					nxt.phase = cur.phase + 5'd2;
				end else begin
					frame_bad = 1'b1;
				end
			end else if (rx_byte != t) begin
				frame_bad = 1'b1;
			end else if (cur.phase == PHASE_LAST) begin
				flags.frame_valid = 1'b1;
				nxt.held  = cur.pending;
				nxt.phase = PHASE_HUNT;
				nxt.kpos  = '0;
				nxt.acc   = '0;
			end else begin
				nxt.phase = cur.phase + 5'd1;
			end
			// a broken frame re-examines the byte as the start of a keyword
			if (frame_bad) begin
				flags.frame_error = 1'b1;
				nxt.phase = PHASE_HUNT;
				nxt.kpos  = {3'b0, is_b};
				nxt.acc   = '0;
			end
		end else if (cur.phase == PHASE_HUNT) begin
			if (cur.kpos < KPOS_PREFIX_END) begin
				if (rx_byte == kw_char(1'b0, cur.kpos)) begin
					nxt.kpos = cur.kpos + 4'd1;
				end else begin
					nxt.kpos = {3'b0, is_b};
				end
			end else if (rx_byte == CH_A) begin
				nxt.phase = PHASE_ACK_TAIL;
				nxt.kpos  = KPOS_TAIL_START;
			end else if (rx_byte == CH_D) begin
				nxt.phase = PHASE_DAT_TAIL;
				nxt.kpos  = KPOS_TAIL_START;
			end else begin
				nxt.kpos = {3'b0, is_b};
			end
		end else begin
			if (cur.kpos < KPOS_KW_LEN
				&& rx_byte == kw_char(cur.phase == PHASE_DAT_TAIL, cur.kpos)) begin
				if (cur.kpos == KPOS_TAIL_LAST) begin
					nxt.kpos = '0;
					if (cur.phase == PHASE_ACK_TAIL) begin
						flags.ack_seen = 1'b1;
						nxt.age   = '0;
						nxt.phase = PHASE_HUNT;
					end else begin
						nxt.phase = PHASE_FRAME;
						nxt.acc   = '0;
					end
				end else begin
					nxt.kpos = cur.kpos + 4'd1;
				end
			end else begin
				nxt.phase = PHASE_HUNT;
				nxt.kpos  = {3'b0, is_b};
			end
		end
		flags.link_up = nxt.link;
	end

endmodule

### rtl/ascii_telemetry_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_telemetry_frame_parser
// Link keyword tracking and telemetry frame parsing, one byte or tick a cycle unless the result side stalls.
// ----------------------------------------------------------------------------
// path: a taken request is registered in the input stage, then in the result stage; a result stall holds both
// throughput: one item per cycle while the result side does not stall; the parser state updates once per item
// reset: asynchronous, link down, parser hunting, held values zero,
// timeout register 2000; no clearing pass, items are taken straight after reset
module ascii_telemetry_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	// frame_valid, frame_error, ack_seen, init_ack_seen, link_up,
	// aileron[20:5], elevator[36:21], throttle[44:37], battery[60:45], zero pad
	output logic [63:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import atfp_pkg::*;

	logic        s1_valid;
	logic        cmd_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic [15:0] timeout_q;
	state_t      st_q;
	state_t      st_nxt;
	flags_t      flags;
	logic        advance;

	// the stage moves on whenever the result slot is free or being emptied
	assign advance   = s1_valid && (!out_valid_q || m_tready);
	assign s_tready  = !s1_valid || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	atfp_step u_step (
		.cur     (st_q),
		.cmd     (cmd_s1),
		.rx_byte (byte_s1),
		.timeout (timeout_q),
		.nxt     (st_nxt),
		.flags   (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
			st_q        <= '0;
		end else begin
			if (s_tready) begin
				s1_valid <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				st_q        <= st_nxt;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			out_data_q <= {3'b0, st_nxt.held, flags};
		end
	end

	a_single_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q[0] && out_data_q[1]))
		else $error("frame closed valid and in error at once");

	a_init_brings_up: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[3] |-> out_data_q[4])
		else $error("init acknowledgement without link up");

	a_frame_needs_link: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase >= PHASE_FRAME |-> st_q.link)
		else $error("frame open while link down");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !advance |=> s1_valid && $stable(byte_s1) && $stable(cmd_s1))
		else $error("stalled input stage lost its item");

endmodule

### sim/ascii_telemetry_frame_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_telemetry_frame_parser_tb
// Self-checking bench for the telemetry frame parser. Bytes and ticks go in
// on the stream slave side. A behavioural copy of the parser works out each
// flag word and the held values, and every result on the master side is
// checked against it in order. Directed tests cover link bring-up, frame
// edge cases and the timeout register. A long random run of frames, broken
// frames, acks, ticks and noise follows, with random gaps on both sides.
// ----------------------------------------------------------------------------
module ascii_telemetry_frame_parser_tb;
	import atfp_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 12;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int MAX_WAIT       = 13;
	localparam int DRAIN_CYCLES   = 4;
	localparam int END_CYCLES     = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam bit CMD_BYTE = 1'b0;
	localparam bit CMD_TICK = 1'b1;

	localparam int unsigned FIELD_AIL = 0;
	localparam int unsigned FIELD_ELV = 1;
	localparam int unsigned FIELD_BAT = 3;

	localparam bit [8*28-1:0] BODY_TEXT = ":AIL#:ELV#:THR#:BAT#:BAS_EOF";
	localparam bit [8*28-1:0] ACK_TEXT  = "BAS_ACK";
	localparam bit [8*28-1:0] DAT_TEXT  = "BAS_DAT";
	localparam bit [8*28-1:0] INIT_TEXT = {"BAS_", "INIT", "_ACK"};
	localparam int ACK_LEN  = 7;
	localparam int INIT_LEN = 12;

	typedef enum int {FRAME_MORE, FRAME_DONE, FRAME_BROKEN} frame_step_t;

	typedef enum int {
		BREAK_OVERFLOW, BREAK_EMPTY_FIELD, BREAK_CORRUPT, BREAK_TRUNCATE
	} frame_break_t;

	// same bit order as m_tdata[60:0]
	typedef struct packed {
		fields_t held;
		logic    link_up;
		logic    init_ack_seen;
		logic    ack_seen;
		logic    frame_error;
		logic    frame_valid;
	} telem_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // rx_byte
	logic        s_tuser = 1'b0;   // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// frame_valid, frame_error, ack_seen, init_ack_seen, link_up,
	// aileron, elevator, throttle, battery, zero pad
	logic [63:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'd0;

	always #CLK_HALF clk = ~clk;

	ascii_telemetry_frame_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// parser shadow state
	int unsigned prs_phase = 0;
	int unsigned kw_pos = 0;
	int unsigned digit_acc = 0;
	fields_t     pend_vals = '0;
	fields_t     held_vals = '0;
	bit          link_on = 1'b0;
	int unsigned tick_age = 0;
	int unsigned timeout_ticks = TIMEOUT_RESET;

	telem_result_t telem_q[$];
	int            fail_count = 0;
	int unsigned   items_sent = 0;
	int            quiet_cycles = 0;
	bit            src_idle_on = 1'b1;
	bit            snk_stall_on = 1'b1;
	int            tick_odds = 0;
	string         noise_chars = "BAS_:AILELVTHRDCKEOFN0123456789";
	string         init_word = {"BAS_", "INIT", "_ACK"};

	function automatic logic [7:0] text_char(input bit [8*28-1:0] txt, input int n,
			input int i);
		return txt[8*(n-1-i) +: 8];
	endfunction

	function automatic void clear_parse();
		prs_phase = PHASE_HUNT;
		kw_pos = 0;
		digit_acc = 0;
	endfunction

	function automatic void restart_search(input logic [7:0] b);
		prs_phase = PHASE_HUNT;
		kw_pos = (b == CH_B) ? 1 : 0;
	endfunction

	// keyword hunt while the link is up, returns 1 when BAS_ACK completes
	function automatic bit search_linked(input logic [7:0] b);
		bit [8*28-1:0] word;
		if (prs_phase == PHASE_HUNT) begin
			if (kw_pos < KPOS_PREFIX_END) begin
				if (b == text_char(ACK_TEXT, ACK_LEN, kw_pos))
					kw_pos++;
				else
					restart_search(b);
			end else if (b == CH_A) begin
				prs_phase = PHASE_ACK_TAIL;
				kw_pos = KPOS_TAIL_START;
			end else if (b == CH_D) begin
				prs_phase = PHASE_DAT_TAIL;
				kw_pos = KPOS_TAIL_START;
			end else begin
				restart_search(b);
			end
			return 1'b0;
		end
		word = (prs_phase == PHASE_ACK_TAIL) ? ACK_TEXT : DAT_TEXT;
		if (kw_pos < ACK_LEN && b == text_char(word, ACK_LEN, kw_pos)) begin
			kw_pos++;
			if (kw_pos == ACK_LEN) begin
				if (prs_phase == PHASE_ACK_TAIL) begin
					tick_age = 0;
					prs_phase = PHASE_HUNT;
					kw_pos = 0;
					return 1'b1;
				end
				prs_phase = PHASE_FRAME;
				kw_pos = 0;
				digit_acc = 0;
			end
		end else begin
			restart_search(b);
		end
		return 1'b0;
	endfunction

	function automatic frame_step_t frame_step(input logic [7:0] b);
		int unsigned pos;
		int unsigned fld;
		int unsigned lim;
		logic [7:0]  want;
		pos = prs_phase - PHASE_FRAME;
		if (pos >= BODY_LEN)
			return FRAME_BROKEN;
		want = text_char(BODY_TEXT, BODY_LEN, pos);
		if (want == CH_DIGIT_MARK) begin
			fld = pos / 5;
			lim = (fld == FIELD_THR) ? LIMIT_NARROW : LIMIT_WIDE;
			if (b >= CH_ZERO && b <= CH_NINE) begin
				digit_acc = digit_acc * 10 + (b - CH_ZERO);
				if (digit_acc > lim)
					return FRAME_BROKEN;
				kw_pos = KPOS_DIGIT_SEEN;
				return FRAME_MORE;
			end
			if (kw_pos == KPOS_DIGIT_SEEN && pos + 1 < BODY_LEN &&
					b == text_char(BODY_TEXT, BODY_LEN, pos + 1)) begin
				case (fld)
					FIELD_AIL: pend_vals.aileron = digit_acc[15:0];
					FIELD_ELV: pend_vals.elevator = digit_acc[15:0];
					FIELD_THR: pend_vals.throttle = digit_acc[7:0];
					default:   pend_vals.battery = digit_acc[15:0];
				endcase
				digit_acc = 0;
				kw_pos = 0;
				prs_phase += 2;
				return FRAME_MORE;
			end
			return FRAME_BROKEN;
		end
		if (b != want)
			return FRAME_BROKEN;
		prs_phase++;
		if (prs_phase - PHASE_FRAME == BODY_LEN) begin
			held_vals = pend_vals;
			clear_parse();
			return FRAME_DONE;
		end
		return FRAME_MORE;
	endfunction

	function automatic telem_result_t predict_step(input bit cmd, input logic [7:0] b);
		telem_result_t r;
		frame_step_t   fs;
		r = '0;
		if (cmd == CMD_TICK) begin
			if (link_on) begin
				if (tick_age < AGE_MAX)
					tick_age++;
				// a frame still open when the link drops is lost quietly
				if (tick_age >= timeout_ticks) begin
					link_on = 1'b0;
					tick_age = 0;
					clear_parse();
				end
			end
		end else if (!link_on) begin
			if (kw_pos < INIT_LEN && b == text_char(INIT_TEXT, INIT_LEN, kw_pos)) begin
				kw_pos++;
				if (kw_pos == INIT_LEN) begin
					r.init_ack_seen = 1'b1;
					link_on = 1'b1;
					tick_age = 0;
					clear_parse();
				end
			end else begin
				restart_search(b);
			end
		end else if (prs_phase >= PHASE_FRAME) begin
			fs = frame_step(b);
			if (fs == FRAME_DONE) begin
				r.frame_valid = 1'b1;
			end else if (fs == FRAME_BROKEN) begin
				// the offending byte gets a second look as hunt input
				r.frame_error = 1'b1;
				clear_parse();
				r.ack_seen = search_linked(b);
			end
		end else begin
			r.ack_seen = search_linked(b);
		end
		r.link_up = link_on;
		r.held = held_vals;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	initial begin : result_checker
		int            stall;
		telem_result_t want;
		telem_result_t got;
		@(posedge arst_n);
		forever begin
			stall = snk_stall_on ? $urandom_range(0, MAX_WAIT) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got = m_tdata[60:0];
			if (telem_q.size() == 0) begin
				$error("result %h with no request outstanding", m_tdata);
				fail_count++;
			end else begin
				want = telem_q.pop_front();
				check_field("frame_valid", want.frame_valid, got.frame_valid);
				check_field("frame_error", want.frame_error, got.frame_error);
				check_field("ack_seen", want.ack_seen, got.ack_seen);
				check_field("init_ack_seen", want.init_ack_seen, got.init_ack_seen);
				check_field("link_up", want.link_up, got.link_up);
				check_field("aileron", want.held.aileron, got.held.aileron);
				check_field("elevator", want.held.elevator, got.held.elevator);
				check_field("throttle", want.held.throttle, got.held.throttle);
				check_field("battery", want.held.battery, got.held.battery);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_item(input bit cmd, input logic [7:0] rx);
		int gap;
		gap = src_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= rx;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		telem_q.push_back(predict_step(cmd, rx));
		items_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
	endtask

	// ticks may be sprinkled between the bytes of a keyword or frame
	task automatic send_text(input string txt);
		int i;
		for (i = 0; i < txt.len(); i++) begin
			if (tick_odds > 0 && $urandom_range(0, tick_odds) == 0)
				send_ticks(1);
			send_item(CMD_BYTE, txt[i]);
		end
	endtask

	task automatic write_timeout(input logic [15:0] value);
		s_tvalid <= 1'b0;
		while (telem_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		timeout_ticks = value;
	endtask

	function automatic string num_text(input int unsigned v, input int zeros);
		string s;
		s = $sformatf("%0d", v);
		repeat (zeros) s = {"0", s};
		return s;
	endfunction

	function automatic string frame_text(input string ail, input string elv,
			input string thr, input string bat);
		return {"BAS_DAT:AIL", ail, ":ELV", elv, ":THR", thr, ":BAT", bat, ":BAS_EOF"};
	endfunction

	function automatic int unsigned field_limit(input int unsigned fld);
		return (fld == FIELD_THR) ? LIMIT_NARROW : LIMIT_WIDE;
	endfunction

	function automatic string rand_num_text(input int unsigned lim);
		int unsigned v;
		case ($urandom_range(0, 5))
			0:       v = 0;
			1:       v = lim;
			2:       v = $urandom_range(0, 99);
			default: v = $urandom_range(0, lim);
		endcase
		return num_text(v, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
	endfunction

	function automatic logic [7:0] rand_char();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(1, 255));
		return noise_chars[$urandom_range(0, noise_chars.len() - 1)];
	endfunction

	task automatic send_good_frame();
		send_text(frame_text(rand_num_text(LIMIT_WIDE), rand_num_text(LIMIT_WIDE),
			rand_num_text(LIMIT_NARROW), rand_num_text(LIMIT_WIDE)));
	endtask

	task automatic send_broken_frame();
		string        nums[4];
		string        txt;
		int unsigned  fld;
		frame_break_t how;
		for (fld = 0; fld < 4; fld++)
			nums[fld] = rand_num_text(field_limit(fld));
		fld = $urandom_range(0, 3);
		how = frame_break_t'($urandom_range(BREAK_OVERFLOW, BREAK_TRUNCATE));
		if (how == BREAK_OVERFLOW)
			nums[fld] = num_text(field_limit(fld) + 1 + $urandom_range(0, 30000),
				$urandom_range(0, 1));
		else if (how == BREAK_EMPTY_FIELD)
			nums[fld] = "";
		txt = frame_text(nums[0], nums[1], nums[2], nums[3]);
		if (how == BREAK_CORRUPT)
			txt.putc($urandom_range(7, txt.len() - 1), rand_char());
		else if (how == BREAK_TRUNCATE)
			txt = {txt.substr(0, $urandom_range(7, txt.len() - 2)),
				($urandom_range(0, 1) == 0) ? "BAS_ACK" : "BAS_DAT"};
		send_text(txt);
	endtask

	task automatic send_noise(input int n);
		repeat (n) begin
			if ($urandom_range(0, 1) == 0)
				send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
			else
				send_item(CMD_BYTE, rand_char());
		end
	endtask

	task automatic test_link_bringup();
		send_ticks(1);
		send_text("BAS_INITX");
		send_text({"B", init_word});
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, 8'hFF);
	endtask

	task automatic test_frame_cases();
		send_text(frame_text("65535", "0", "255", "00012"));
		send_text("BAS_DAT:AIL65536");
		send_text("BAS_DAT:AIL1:ELV2:THR256");
		send_text("BAS_DAT:AIL:ELV");
		send_text("BAS_DAT:AIL9/");
		// a bad byte inside a frame may itself open the next keyword
		send_text("BAS_DAT:AIL7BAS_ACK");
		send_text({"BAS_DAT", frame_text("1", "2", "3", "4")});
		send_text(frame_text("00000", "65535", "0", "65535"));
	endtask

	task automatic test_timeout_register();
		write_timeout(16'd4);
		send_ticks(3);
		send_text("BAS_ACK");
		send_ticks(4);
		send_text(init_word);
		write_timeout(16'd3);
		send_text("BAS_DAT:AIL12");
		send_ticks(3);
		send_text(":ELV5");
		write_timeout(16'd1);
		send_text(init_word);
		send_ticks(1);
		write_timeout(16'd0);
		send_text(init_word);
		send_ticks(1);
		// longest timeout, a burst of ticks without gaps keeps the link up
		write_timeout(16'hFFFF);
		send_text(init_word);
		src_idle_on = 1'b0;
		snk_stall_on = 1'b0;
		send_ticks(20);
		src_idle_on = 1'b1;
		snk_stall_on = 1'b1;
		write_timeout(TIMEOUT_RESET);
	endtask

	task automatic test_random_traffic();
		int unsigned goal;
		int          pick;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			if ($urandom_range(0, 15) == 0) begin
				src_idle_on = $urandom_range(0, 2) != 0;
				snk_stall_on = $urandom_range(0, 2) != 0;
			end
			tick_odds = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : 0;
			if (!link_on && $urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 2) == 0)
					send_noise($urandom_range(1, 4));
				send_text(init_word);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					send_good_frame();
				else if (pick < 60)
					send_broken_frame();
				else if (pick < 70)
					send_text("BAS_ACK");
				else if (pick < 80)
					send_ticks($urandom_range(1, 6));
				else if (pick < 90)
					send_noise($urandom_range(1, 8));
				else if (pick < 95)
					send_text(init_word);
				else if ($urandom_range(0, 1) == 0)
					write_timeout(16'($urandom_range(1, 30)));
				else
					write_timeout(($urandom_range(0, 3) == 0) ? 16'hFFFF :
						16'($urandom_range(31, 65535)));
			end
		end
		tick_odds = 0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_link_bringup();
		test_frame_cases();
		test_timeout_register();
		test_random_traffic();
		s_tvalid <= 1'b0;
		while (telem_q.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### ascii_telemetry_frame_parser.f
rtl/atfp_pkg.sv
rtl/atfp_step.sv
rtl/ascii_telemetry_frame_parser.sv
sim/ascii_telemetry_frame_parser_tb.sv
